/* sv/bpc_pkg.sv */
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } bpc_event_t;

  typedef enum logic [2:0] {
    REG_POLARITY  = 3'd0,
    REG_DEBOUNCE  = 3'd1,
    REG_LONG      = 3'd2,
    REG_REPEAT    = 3'd3,
    REG_DOUBLE    = 3'd4,
    REG_REPEAT_EN = 3'd5
  } bpc_reg_t;

  typedef struct packed {
    logic        polarity_active_low;
    logic [15:0] debounce_time;
    logic [15:0] long_press_time;
    logic [15:0] repeat_time;
    logic [15:0] double_click_time;
    logic        repeat_enable;
  } bpc_cfg_t;

  typedef struct packed {
    logic             raw_level;
    logic [TimeW-1:0] time_ms;
  } bpc_sample_t;

  typedef struct packed {
    bpc_event_t event_res;
    logic       pressed_now;
  } bpc_result_t;

endpackage

/* sv/button_press_classifier_unit.sv */
`timescale 1ns / 1ps
// Channel  Direction  Transaction contents
// in_      slave      tdata[0] raw_level, tdata[32:1] time_ms
// out_     master     tdata[1:0] event_res, tdata[2] pressed_now
// cfg_     APB        six registers at byte address 4*index
//
// One sample per cycle sustained unless out_ stalls; a result reaches out_
// via the input register, then the classifier step into the result
// register. Synchronous active-low reset clears all press state and loads
// the default register values. A stalled out_ side holds the result
// register and back-pressures in_ through the input register.

module button_press_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] raw_level, [32:1] time_ms, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] event_res, [2] pressed_now, [7:3] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [bpc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [bpc_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [bpc_pkg::CfgDataW-1:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpc_pkg::*;

  bpc_cfg_t    cfg;
  bpc_sample_t in_sample, s_sample;
  bpc_result_t result;
  logic        s_valid, s_ready;

  assign in_sample.raw_level = in_tdata[0];
  assign in_sample.time_ms   = in_tdata[32:1];
  assign out_tdata = {5'd0, result.pressed_now, result.event_res};

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bpc_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_sample),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_sample  (s_sample)
  );

  bpc_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_sample   (s_sample),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (result)
  );

endmodule

/* sv/bpc_cfg_regs.sv */
`timescale 1ns / 1ps

module bpc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bpc_pkg::CfgAddrW-1:0] paddr,
  input  logic [bpc_pkg::CfgDataW-1:0] pwdata,
  output logic [bpc_pkg::CfgDataW-1:0] prdata,
  output logic                      pready,
  output bpc_pkg::bpc_cfg_t         cfg
);
  import bpc_pkg::*;

  bpc_cfg_t cfg_r;
  logic     wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polarity_active_low <= 1'b1;
      cfg_r.debounce_time       <= 16'd50;
      cfg_r.long_press_time     <= 16'd1000;
      cfg_r.repeat_time         <= 16'd200;
      cfg_r.double_click_time   <= 16'd300;
      cfg_r.repeat_enable       <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_POLARITY:  cfg_r.polarity_active_low <= pwdata[0];
        REG_DEBOUNCE:  cfg_r.debounce_time       <= pwdata[15:0];
        REG_LONG:      cfg_r.long_press_time     <= pwdata[15:0];
        REG_REPEAT:    cfg_r.repeat_time         <= pwdata[15:0];
        REG_DOUBLE:    cfg_r.double_click_time   <= pwdata[15:0];
        REG_REPEAT_EN: cfg_r.repeat_enable       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_POLARITY:  prdata = {31'd0, cfg_r.polarity_active_low};
      REG_DEBOUNCE:  prdata = {16'd0, cfg_r.debounce_time};
      REG_LONG:      prdata = {16'd0, cfg_r.long_press_time};
      REG_REPEAT:    prdata = {16'd0, cfg_r.repeat_time};
      REG_DOUBLE:    prdata = {16'd0, cfg_r.double_click_time};
      REG_REPEAT_EN: prdata = {31'd0, cfg_r.repeat_enable};
      default:       prdata = '0;
    endcase
  end

endmodule

/* sv/bpc_in_reg.sv */
`timescale 1ns / 1ps

module bpc_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bpc_pkg::bpc_sample_t  in_sample,
  output logic                  s_valid,
  input  logic                  s_ready,
  output bpc_pkg::bpc_sample_t  s_sample
);
  import bpc_pkg::*;

  logic        valid_r;
  bpc_sample_t sample_r;

  assign in_ready = ~valid_r | s_ready;
  assign s_valid  = valid_r;
  assign s_sample = sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sample_r <= in_sample;
    end
  end

endmodule

/* sv/bpc_step.sv */
`timescale 1ns / 1ps

module bpc_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpc_pkg::bpc_cfg_t     cfg,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  bpc_pkg::bpc_sample_t  s_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bpc_pkg::bpc_result_t  out_result
);
  import bpc_pkg::*;

  logic             seeded_r, stable_r, long_held_r, awaiting_r;
  logic [TimeW-1:0] last_change_r, press_start_r, last_repeat_r, last_release_r;
  logic             stable_nxt, long_held_nxt, awaiting_nxt;
  logic [TimeW-1:0] last_change_nxt, press_start_nxt, last_repeat_nxt, last_release_nxt;
  logic             out_valid_r;
  bpc_result_t      result_r, result_nxt;

  logic             load;
  logic             cur, stable_eff, edge_ok, short_rel, long_first, long_rep, expired;
  logic [TimeW-1:0] now, d_chg, d_press, d_rep, d_rel;

  assign s_ready    = ~out_valid_r | out_ready;
  assign load       = s_valid & s_ready;
  assign out_valid  = out_valid_r;
  assign out_result = result_r;

  assign now        = s_sample.time_ms;
  assign cur        = cfg.polarity_active_low ? ~s_sample.raw_level : s_sample.raw_level;
  assign stable_eff = seeded_r ? stable_r : cur;
  assign d_chg      = now - last_change_r;
  assign d_press    = now - press_start_r;
  assign d_rep      = now - last_repeat_r;
  assign d_rel      = now - last_release_r;

  always_comb begin
    stable_nxt       = stable_eff;
    long_held_nxt    = long_held_r;
    awaiting_nxt     = awaiting_r;
    last_change_nxt  = last_change_r;
    press_start_nxt  = press_start_r;
    last_repeat_nxt  = last_repeat_r;
    last_release_nxt = last_release_r;
    result_nxt.event_res   = EV_NONE;
    result_nxt.pressed_now = cur;

    edge_ok   = (cur != stable_eff) && (d_chg > {16'd0, cfg.debounce_time});
    short_rel = edge_ok && !cur && !long_held_r
                && (d_press < {16'd0, cfg.long_press_time});
    // the press start is not yet restarted on a fresh press edge, so !edge_ok keeps that sample from being long
    long_first = cur && !edge_ok && !long_held_r
                 && (d_press > {16'd0, cfg.long_press_time});
    long_rep   = cur && !edge_ok && long_held_r && cfg.repeat_enable
                 && (d_press > {16'd0, cfg.long_press_time})
                 && (d_rep > {16'd0, cfg.repeat_time});
    expired    = awaiting_r && !short_rel && !long_first
                 && (d_rel > {16'd0, cfg.double_click_time});

    if (edge_ok) begin
      last_change_nxt = now;
      stable_nxt      = cur;
      long_held_nxt   = 1'b0;
      if (cur) begin
        press_start_nxt = now;
      end
    end

    if (short_rel) begin
      if (awaiting_r && (d_rel < {16'd0, cfg.double_click_time})) begin
        result_nxt.event_res = EV_DOUBLE;
        awaiting_nxt         = 1'b0;
      end else begin
        awaiting_nxt     = 1'b1;
        last_release_nxt = now;
      end
    end

    if (long_first) begin
      long_held_nxt        = 1'b1;
      awaiting_nxt         = 1'b0;
      last_repeat_nxt      = now;
      result_nxt.event_res = EV_LONG;
    end else if (long_rep) begin
      last_repeat_nxt      = now;
      result_nxt.event_res = EV_LONG;
    end

    if (expired) begin
      result_nxt.event_res = EV_SHORT;
      awaiting_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r       <= 1'b0;
      stable_r       <= 1'b0;
      long_held_r    <= 1'b0;
      awaiting_r     <= 1'b0;
      last_change_r  <= '0;
      press_start_r  <= '0;
      last_repeat_r  <= '0;
      last_release_r <= '0;
    end else if (load) begin
      seeded_r       <= 1'b1;
      stable_r       <= stable_nxt;
      long_held_r    <= long_held_nxt;
      awaiting_r     <= awaiting_nxt;
      last_change_r  <= last_change_nxt;
      press_start_r  <= press_start_nxt;
      last_repeat_r  <= last_repeat_nxt;
      last_release_r <= last_release_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_ready) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_nxt;
    end
  end

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result register valid after reset");
  a_double_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (load && result_nxt.event_res == EV_DOUBLE) |-> !cur)
    else $error("double click reported while pressed");
  a_long_when_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (load && result_nxt.event_res == EV_LONG) |=> (long_held_r && out_result.pressed_now))
    else $error("long press without held state");
  a_short_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (load && result_nxt.event_res == EV_SHORT) |=> !awaiting_r)
    else $error("short press left window open");
`endif

endmodule
